// ===== design/cbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Cascaded balance PID package
// Shared types, gain reset values, limits and saturation helpers for the
// three-loop balance controller.
// ----------------------------------------------------------------------------
package cbp_pkg;

    typedef struct packed {
        logic signed [23:0] wheel_speed;
        logic signed [23:0] roll_angle;
        logic signed [23:0] roll_rate;
        logic signed [23:0] balance_target;
    } in_item_t;

    typedef struct packed {
        logic signed [19:0] drive;
        logic               stopped;
    } out_item_t;

    typedef struct packed {
        logic signed [23:0] speed_kp;
        logic signed [23:0] speed_ki;
        logic signed [23:0] angle_kp;
        logic signed [23:0] angle_ki;
        logic signed [23:0] angle_kd;
        logic signed [23:0] rate_kp;
        logic signed [23:0] rate_ki;
        logic signed [23:0] rate_kd;
    } gains_t;

    typedef enum logic [2:0] {
        REG_SPEED_KP = 3'd0,
        REG_SPEED_KI = 3'd1,
        REG_ANGLE_KP = 3'd2,
        REG_ANGLE_KI = 3'd3,
        REG_ANGLE_KD = 3'd4,
        REG_RATE_KP  = 3'd5,
        REG_RATE_KI  = 3'd6,
        REG_RATE_KD  = 3'd7
    } cfg_index_t;

    localparam gains_t GAIN_RESET = '{
        speed_kp: 24'sd0,
        speed_ki: 24'sd0,
        angle_kp: -24'sd1310720,
        angle_ki: 24'sd465,
        angle_kd: 24'sd426,
        rate_kp:  24'sd229376,
        rate_ki:  24'sd32768,
        rate_kd:  24'sd170394
    };

    localparam logic [2:0]         ANGLE_DIVIDE  = 3'd2;
    localparam logic [2:0]         SPEED_DIVIDE  = 3'd5;
    localparam logic signed [23:0] SPEED_D_GAIN  = 24'sd0;

    localparam logic signed [35:0] OUT_LIMIT     = 36'sd512000;
    localparam logic signed [24:0] SPEED_I_LIMIT = 25'sd76800;
    localparam logic signed [24:0] ANGLE_I_LIMIT = 25'sd256000;
    localparam logic signed [24:0] RATE_I_LIMIT  = 25'sd256000;
    localparam logic signed [23:0] TILT_LIMIT    = 24'sd5120;
    localparam logic signed [25:0] E24_MAX       = 26'sd8388607;
    localparam logic signed [25:0] E24_MIN       = -26'sd8388608;
    localparam logic signed [51:0] ROUND_HALF    = 52'sd32768;

    // Saturates a widened error back into the signed 24-bit range.
    function automatic logic signed [23:0] sat_err(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > E24_MAX) begin
            r = 24'sh7FFFFF;
        end else if (v < E24_MIN) begin
            r = -24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Clamps a value to the symmetric range given by lim.
    function automatic logic signed [24:0] clamp_sym(input logic signed [24:0] v,
                                                     input logic signed [24:0] lim);
        logic signed [24:0] r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/cbp_gain_regs.sv =====
// ----------------------------------------------------------------------------
// Gain register file
// Holds the eight loop gains and takes writes from the configuration port.
// ----------------------------------------------------------------------------
module cbp_gain_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [23:0]     cfg_data,
    output cbp_pkg::gains_t gains
);

    cbp_pkg::gains_t gains_reg;
    cbp_pkg::gains_t gains_next;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_we)
        begin
            unique case (cbp_pkg::cfg_index_t'(cfg_index))
                cbp_pkg::REG_SPEED_KP: gains_next.speed_kp = cfg_data;
                cbp_pkg::REG_SPEED_KI: gains_next.speed_ki = cfg_data;
                cbp_pkg::REG_ANGLE_KP: gains_next.angle_kp = cfg_data;
                cbp_pkg::REG_ANGLE_KI: gains_next.angle_ki = cfg_data;
                cbp_pkg::REG_ANGLE_KD: gains_next.angle_kd = cfg_data;
                cbp_pkg::REG_RATE_KP:  gains_next.rate_kp  = cfg_data;
                cbp_pkg::REG_RATE_KI:  gains_next.rate_ki  = cfg_data;
                cbp_pkg::REG_RATE_KD:  gains_next.rate_kd  = cfg_data;
                default:               gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= cbp_pkg::GAIN_RESET;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    assign gains = gains_reg;

endmodule

// ===== design/cbp_pid_term.sv =====
// ----------------------------------------------------------------------------
// PID term
// Forms kp*e + ki*i + kd*de in Q.24, rounds to Q.8 and saturates the
// result to plus or minus 2000.0.
// ----------------------------------------------------------------------------
module cbp_pid_term (
    input  logic signed [23:0] kp,
    input  logic signed [23:0] ki,
    input  logic signed [23:0] kd,
    input  logic signed [23:0] err,
    input  logic signed [18:0] integ,
    input  logic signed [24:0] derr,
    output logic signed [19:0] term
);

    logic signed [47:0] p_prod;
    logic signed [42:0] i_prod;
    logic signed [48:0] d_prod;
    logic signed [51:0] acc;
    logic signed [35:0] rounded;

    assign p_prod = kp * err;
    assign i_prod = ki * integ;
    assign d_prod = kd * derr;

    assign acc = $signed({{4{p_prod[47]}}, p_prod})
               + $signed({{9{i_prod[42]}}, i_prod})
               + $signed({{3{d_prod[48]}}, d_prod})
               + cbp_pkg::ROUND_HALF;

    assign rounded = acc[51:16];

    always_comb
    begin
        if (rounded > cbp_pkg::OUT_LIMIT)
        begin
            term = cbp_pkg::OUT_LIMIT[19:0];
        end
        else if (rounded < -cbp_pkg::OUT_LIMIT)
        begin
            term = -cbp_pkg::OUT_LIMIT[19:0];
        end
        else
        begin
            term = rounded[19:0];
        end
    end

endmodule

// ===== design/cbp_core.sv =====
// ----------------------------------------------------------------------------
// Loop core
// Holds the state of the speed, angle and rate loops and computes one
// result from the registered request and the stored state.
// ----------------------------------------------------------------------------
module cbp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  cbp_pkg::in_item_t  item_in,
    input  cbp_pkg::gains_t    gains,
    output cbp_pkg::out_item_t result_next
);

    logic signed [17:0] speed_int_reg;
    logic signed [23:0] speed_last_reg;
    logic signed [19:0] speed_out_reg;
    logic signed [18:0] angle_int_reg;
    logic signed [23:0] angle_last_reg;
    logic signed [19:0] angle_out_reg;
    logic signed [23:0] rate_last_reg;
    logic [2:0]         angle_cnt_reg;
    logic [2:0]         speed_cnt_reg;

    logic               in_window;
    logic [2:0]         angle_cnt_inc;
    logic [2:0]         speed_cnt_inc;
    logic               angle_run;
    logic               speed_run;
    logic [2:0]         angle_cnt_next;
    logic [2:0]         speed_cnt_next;

    logic signed [24:0] rate_e_wide;
    logic signed [23:0] rate_e;
    logic signed [24:0] rate_i_wide;
    logic signed [18:0] rate_i;
    logic signed [24:0] rate_de;
    logic signed [19:0] rate_term;

    logic signed [25:0] angle_e_wide;
    logic signed [23:0] angle_e;
    logic signed [24:0] angle_sum;
    logic signed [24:0] angle_int_wide;
    logic signed [18:0] angle_int_next;
    logic signed [24:0] angle_de;
    logic signed [19:0] angle_term;

    logic signed [23:0] speed_e;
    logic signed [24:0] speed_sum;
    logic signed [24:0] speed_int_wide;
    logic signed [17:0] speed_int_next;
    logic signed [24:0] speed_de;
    logic signed [19:0] speed_term;

    assign in_window = (item_in.roll_angle < cbp_pkg::TILT_LIMIT)
                    && (item_in.roll_angle > -cbp_pkg::TILT_LIMIT);

    assign angle_cnt_inc  = angle_cnt_reg + 3'd1;
    assign speed_cnt_inc  = speed_cnt_reg + 3'd1;
    assign angle_run      = angle_cnt_inc >= cbp_pkg::ANGLE_DIVIDE;
    assign speed_run      = speed_cnt_inc >= cbp_pkg::SPEED_DIVIDE;
    assign angle_cnt_next = angle_run ? 3'd0 : angle_cnt_inc;
    assign speed_cnt_next = speed_run ? 3'd0 : speed_cnt_inc;

    // Rate loop: the integral term is the current error, clamped.
    assign rate_e_wide = $signed({{5{angle_out_reg[19]}}, angle_out_reg})
                       - $signed({item_in.roll_rate[23], item_in.roll_rate});
    assign rate_e      = cbp_pkg::sat_err({rate_e_wide[24], rate_e_wide});
    assign rate_i_wide = cbp_pkg::clamp_sym({rate_e[23], rate_e}, cbp_pkg::RATE_I_LIMIT);
    assign rate_i      = rate_i_wide[18:0];
    assign rate_de     = $signed({rate_e[23], rate_e})
                       - $signed({rate_last_reg[23], rate_last_reg});

    cbp_pid_term u_rate_term (
        .kp    (gains.rate_kp),
        .ki    (gains.rate_ki),
        .kd    (gains.rate_kd),
        .err   (rate_e),
        .integ (rate_i),
        .derr  (rate_de),
        .term  (rate_term)
    );

    // Angle loop.
    assign angle_e_wide   = $signed({{6{speed_out_reg[19]}}, speed_out_reg})
                          + $signed({{2{item_in.balance_target[23]}}, item_in.balance_target})
                          - $signed({{2{item_in.roll_angle[23]}}, item_in.roll_angle});
    assign angle_e        = cbp_pkg::sat_err(angle_e_wide);
    assign angle_sum      = $signed({{6{angle_int_reg[18]}}, angle_int_reg})
                          + $signed({angle_e[23], angle_e});
    assign angle_int_wide = cbp_pkg::clamp_sym(angle_sum, cbp_pkg::ANGLE_I_LIMIT);
    assign angle_int_next = angle_int_wide[18:0];
    assign angle_de       = $signed({angle_e[23], angle_e})
                          - $signed({angle_last_reg[23], angle_last_reg});

    cbp_pid_term u_angle_term (
        .kp    (gains.angle_kp),
        .ki    (gains.angle_ki),
        .kd    (gains.angle_kd),
        .err   (angle_e),
        .integ (angle_int_next),
        .derr  (angle_de),
        .term  (angle_term)
    );

    // Speed loop.
    assign speed_e        = item_in.wheel_speed;
    assign speed_sum      = $signed({{7{speed_int_reg[17]}}, speed_int_reg})
                          + $signed({speed_e[23], speed_e});
    assign speed_int_wide = cbp_pkg::clamp_sym(speed_sum, cbp_pkg::SPEED_I_LIMIT);
    assign speed_int_next = speed_int_wide[17:0];
    assign speed_de       = $signed({speed_e[23], speed_e})
                          - $signed({speed_last_reg[23], speed_last_reg});

    cbp_pid_term u_speed_term (
        .kp    (gains.speed_kp),
        .ki    (gains.speed_ki),
        .kd    (cbp_pkg::SPEED_D_GAIN),
        .err   (speed_e),
        .integ ({speed_int_next[17], speed_int_next}),
        .derr  (speed_de),
        .term  (speed_term)
    );

    assign result_next.drive   = in_window ? rate_term : 20'sd0;
    assign result_next.stopped = !in_window;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_int_reg  <= '0;
            speed_last_reg <= '0;
            speed_out_reg  <= '0;
            angle_int_reg  <= '0;
            angle_last_reg <= '0;
            angle_out_reg  <= '0;
            rate_last_reg  <= '0;
            angle_cnt_reg  <= '0;
            speed_cnt_reg  <= '0;
        end
        else if (advance && in_window)
        begin
            rate_last_reg <= rate_e;
            angle_cnt_reg <= angle_cnt_next;
            speed_cnt_reg <= speed_cnt_next;
            if (angle_run)
            begin
                angle_int_reg  <= angle_int_next;
                angle_last_reg <= angle_e;
                angle_out_reg  <= angle_term;
            end
            if (speed_run)
            begin
                speed_int_reg  <= speed_int_next;
                speed_last_reg <= speed_e;
                speed_out_reg  <= speed_term;
            end
        end
    end

`ifndef SYNTHESIS
    a_angle_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_cnt_reg < cbp_pkg::ANGLE_DIVIDE)
        else $error("angle tick counter reached its divide value");

    a_speed_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_cnt_reg < cbp_pkg::SPEED_DIVIDE)
        else $error("speed tick counter reached its divide value");

    a_state_frozen_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_window) |=> ($stable(angle_cnt_reg) && $stable(rate_last_reg)
                                     && $stable(angle_out_reg) && $stable(speed_out_reg)))
        else $error("loop state changed on a tick outside the tilt window");

    a_integrals_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_int_reg <= $signed(cbp_pkg::ANGLE_I_LIMIT[18:0])
         && angle_int_reg >= -$signed(cbp_pkg::ANGLE_I_LIMIT[18:0]))
        && $signed({{7{speed_int_reg[17]}}, speed_int_reg}) <= cbp_pkg::SPEED_I_LIMIT
        && $signed({{7{speed_int_reg[17]}}, speed_int_reg}) >= -cbp_pkg::SPEED_I_LIMIT)
        else $error("loop integral outside its clamp range");
`endif

endmodule

// ===== design/cascaded_balance_pid.sv =====
// ----------------------------------------------------------------------------
// Cascaded balance PID controller
// Three cascaded PID loops (speed, angle, angular rate) for a self-balancing
// vehicle, producing one motor drive result per control tick.
// ----------------------------------------------------------------------------
// Usage:
// One request on the item channel is one control tick: wheel speed, roll
// angle, roll rate and balance target, all signed Q16.8. Each request gives
// exactly one result on the result channel: the motor drive in Q12.8 and a
// stopped flag that is set, with zero drive, when the roll angle is at or
// beyond plus or minus 20 degrees.
// A request is registered at acceptance and its result is registered when the
// request advances, which a receiver stall can hold back. A new request is taken
// every cycle unless the receiver stalls; the rate is set by the single pass of
// three parallel multipliers per loop between the request and result registers.
// When the receiver stalls, the result register holds and one more request is
// still taken into the request register; item_stall rises only then.
// Reset empties both registers, clears all loop state and tick counters and
// loads the gain defaults. Gains are written through cfg_we, cfg_index and
// cfg_data while no request is in flight.
// ----------------------------------------------------------------------------
module cascaded_balance_pid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  cbp_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output cbp_pkg::out_item_t result,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    cbp_pkg::gains_t    gains;
    cbp_pkg::out_item_t result_calc;

    logic               req_valid_reg;
    logic               req_valid_next;
    cbp_pkg::in_item_t  req_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    cbp_pkg::out_item_t res_reg;
    logic               advance;
    logic               take;

    assign advance    = req_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = req_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    assign req_valid_next = take || (req_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && result_stall);

    cbp_gain_regs u_gain_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    cbp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item_in     (req_reg),
        .gains       (gains),
        .result_next (result_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= item;
        end
        if (advance)
        begin
            res_reg <= result_calc;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_stopped_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.stopped) |-> (result.drive == 20'sd0))
        else $error("stopped result carries a nonzero drive");

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.drive <= 20'sd512000 && result.drive >= -20'sd512000))
        else $error("drive outside its saturation range");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (req_valid_reg && res_valid_reg && result_stall))
        else $error("item channel stalled with room in the pipeline");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("request moved on without a result");
`endif

endmodule

// ===== dv/cascaded_balance_pid_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cascaded balance PID regression
// Drives control-tick requests through the three-loop balance controller with
// random idling and stalls on both channels, predicts each drive result with
// an independent fixed-point model of the speed, angle and rate loops, and
// compares every result field by field. Gains are rewritten between phases,
// including both extremes.
// ----------------------------------------------------------------------------
module cascaded_balance_pid_tb;

    localparam longint OUT_MAX        = 512000;
    localparam longint SPEED_INT_MAX  = 76800;
    localparam longint ANGLE_INT_MAX  = 256000;
    localparam longint RATE_INT_MAX   = 256000;
    localparam longint TILT_MAX       = 5120;
    localparam longint ERR_MAX        = 8388607;
    localparam longint ERR_MIN        = -8388608;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     LONG_HOLD      = 64;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    cbp_pkg::in_item_t  item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    cbp_pkg::out_item_t result;
    logic               cfg_we       = 1'b0;
    logic [2:0]         cfg_index    = cbp_pkg::REG_SPEED_KP;
    logic [23:0]        cfg_data     = '0;

    cbp_pkg::in_item_t  tick_q [$];
    cbp_pkg::out_item_t drive_expect_q [$];

    cbp_pkg::gains_t gains_now = cbp_pkg::GAIN_RESET;
    longint speed_acc       = 0;
    longint speed_prev_err  = 0;
    longint speed_cmd       = 0;
    longint angle_acc       = 0;
    longint angle_prev_err  = 0;
    longint angle_cmd       = 0;
    longint rate_prev_err   = 0;
    int     angle_ticks     = 0;
    int     speed_ticks     = 0;

    int mismatches   = 0;
    int ticks_taken  = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit item_taken   = 1'b0;
    bit calm         = 1'b0;

    cascaded_balance_pid u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        longint r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    function automatic longint loop_term(input longint kp, input longint ki, input longint kd,
                                         input longint err, input longint integ,
                                         input longint delta);
        longint acc;
        acc = kp * err + ki * integ + kd * delta;
        acc = (acc + 64'sd32768) >>> 16;
        return clip(acc, -OUT_MAX, OUT_MAX);
    endfunction

    task automatic predict_balance_tick(input cbp_pkg::in_item_t t);
        longint             roll;
        longint             err;
        longint             drv;
        cbp_pkg::out_item_t want;
        roll = longint'(t.roll_angle);
        want = '0;
        if (roll >= TILT_MAX || roll <= -TILT_MAX)
        begin
            want.stopped = 1'b1;
        end
        else
        begin
            angle_ticks = (angle_ticks + 1) % 8;
            speed_ticks = (speed_ticks + 1) % 8;

            err = clip(angle_cmd - longint'(t.roll_rate), ERR_MIN, ERR_MAX);
            drv = loop_term(gains_now.rate_kp, gains_now.rate_ki, gains_now.rate_kd, err,
                            clip(err, -RATE_INT_MAX, RATE_INT_MAX), err - rate_prev_err);
            rate_prev_err = err;

            if (angle_ticks >= int'(cbp_pkg::ANGLE_DIVIDE))
            begin
                angle_ticks = 0;
                err = clip(speed_cmd + longint'(t.balance_target) - roll, ERR_MIN, ERR_MAX);
                angle_acc = clip(angle_acc + err, -ANGLE_INT_MAX, ANGLE_INT_MAX);
                angle_cmd = loop_term(gains_now.angle_kp, gains_now.angle_ki,
                                      gains_now.angle_kd, err, angle_acc,
                                      err - angle_prev_err);
                angle_prev_err = err;
            end

            if (speed_ticks >= int'(cbp_pkg::SPEED_DIVIDE))
            begin
                speed_ticks = 0;
                err = longint'(t.wheel_speed);
                speed_acc = clip(speed_acc + err, -SPEED_INT_MAX, SPEED_INT_MAX);
                speed_cmd = loop_term(gains_now.speed_kp, gains_now.speed_ki,
                                      longint'(cbp_pkg::SPEED_D_GAIN), err, speed_acc,
                                      err - speed_prev_err);
                speed_prev_err = err;
            end
            want.drive = drv[19:0];
        end
        drive_expect_q.push_back(want);
    endtask

    task automatic report_mismatch(input string what, input longint got_v,
                                   input longint want_v);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got_v, want_v);
        mismatches = mismatches + 1;
    endtask

    task automatic push_tick(input longint ws, input longint roll, input longint rate,
                             input longint tgt);
        cbp_pkg::in_item_t t;
        t.wheel_speed    = ws[23:0];
        t.roll_angle     = roll[23:0];
        t.roll_rate      = rate[23:0];
        t.balance_target = tgt[23:0];
        tick_q.push_back(t);
    endtask

    function automatic longint pick_value(input int span);
        logic signed [23:0] raw;
        longint             r;
        raw = 24'($urandom());
        case ($urandom_range(0, 7))
            0: r = longint'(raw);
            1: r = $urandom_range(0, 1) ? ERR_MAX : ERR_MIN;
            default: r = longint'($urandom_range(0, 2 * span)) - span;
        endcase
        return r;
    endfunction

    function automatic longint pick_roll();
        logic signed [23:0] raw;
        longint             r;
        raw = 24'($urandom());
        case ($urandom_range(0, 19))
            0: r = longint'(raw);
            1:
            begin
                r = $urandom_range(0, 1) ? TILT_MAX - 1 : TILT_MAX;
                if ($urandom_range(0, 1))
                begin
                    r = -r;
                end
            end
            default: r = longint'($urandom_range(0, 2 * (TILT_MAX - 1))) - (TILT_MAX - 1);
        endcase
        return r;
    endfunction

    task automatic queue_random_ticks(input int count);
        repeat (count)
        begin
            push_tick(pick_value(30000), pick_roll(), pick_value(60000), pick_value(3000));
        end
    endtask

    function automatic logic signed [23:0] random_gain(input int shift);
        logic signed [23:0] raw;
        raw = 24'($urandom());
        return raw >>> shift;
    endfunction

    function automatic cbp_pkg::gains_t random_gains(input int shift);
        cbp_pkg::gains_t g;
        g.speed_kp = random_gain(shift);
        g.speed_ki = random_gain(shift);
        g.angle_kp = random_gain(shift);
        g.angle_ki = random_gain(shift);
        g.angle_kd = random_gain(shift);
        g.rate_kp  = random_gain(shift);
        g.rate_ki  = random_gain(shift);
        g.rate_kd  = random_gain(shift);
        return g;
    endfunction

    task automatic write_gain(input cbp_pkg::cfg_index_t idx, input logic signed [23:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            cbp_pkg::REG_SPEED_KP: gains_now.speed_kp = value;
            cbp_pkg::REG_SPEED_KI: gains_now.speed_ki = value;
            cbp_pkg::REG_ANGLE_KP: gains_now.angle_kp = value;
            cbp_pkg::REG_ANGLE_KI: gains_now.angle_ki = value;
            cbp_pkg::REG_ANGLE_KD: gains_now.angle_kd = value;
            cbp_pkg::REG_RATE_KP:  gains_now.rate_kp  = value;
            cbp_pkg::REG_RATE_KI:  gains_now.rate_ki  = value;
            cbp_pkg::REG_RATE_KD:  gains_now.rate_kd  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_gains(input cbp_pkg::gains_t g);
        write_gain(cbp_pkg::REG_SPEED_KP, g.speed_kp);
        write_gain(cbp_pkg::REG_SPEED_KI, g.speed_ki);
        write_gain(cbp_pkg::REG_ANGLE_KP, g.angle_kp);
        write_gain(cbp_pkg::REG_ANGLE_KI, g.angle_ki);
        write_gain(cbp_pkg::REG_ANGLE_KD, g.angle_kd);
        write_gain(cbp_pkg::REG_RATE_KP,  g.rate_kp);
        write_gain(cbp_pkg::REG_RATE_KI,  g.rate_ki);
        write_gain(cbp_pkg::REG_RATE_KD,  g.rate_kd);
    endtask

    task automatic wait_all_results();
        while (tick_q.size() != 0 || item_valid || drive_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Request side: an offered request is held until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || item_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                item_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                send_gap = $urandom_range(0, 5);
                item_valid <= 1'b0;
            end
            else if (tick_q.size() > 0)
            begin
                item       <= tick_q.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Result side: short random stalls, plus one long hold-off while requests
    // keep coming so that the controller backs up and stalls its input.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (!hold_done && ticks_taken >= 400 && tick_q.size() > 30)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cbp_pkg::out_item_t want;
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            item_taken = item_valid && !item_stall;
            if (item_taken)
            begin
                predict_balance_tick(item);
                ticks_taken  = ticks_taken + 1;
                quiet_cycles = 0;
            end
            if (result_valid && !result_stall)
            begin
                quiet_cycles = 0;
                results_seen = results_seen + 1;
                if (drive_expect_q.size() == 0)
                begin
                    report_mismatch("result with no pending request",
                                    longint'(result.drive), longint'(0));
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    if (result.drive !== want.drive)
                    begin
                        report_mismatch("drive", longint'(result.drive),
                                        longint'(want.drive));
                    end
                    if (result.stopped !== want.stopped)
                    begin
                        report_mismatch("stopped", longint'(result.stopped),
                                        longint'(want.stopped));
                    end
                end
            end
            if (cfg_we)
            begin
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         quiet_cycles, drive_expect_q.size());
                $display("cascaded_balance_pid regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Corners at the reset gains: tilt window edges, field extremes and
        // saturated angle and rate errors, long enough to run both outer loops.
        push_tick(0, 0, 0, 0);
        push_tick(ERR_MAX, TILT_MAX - 1, 0, 0);
        push_tick(ERR_MIN, -(TILT_MAX - 1), ERR_MAX, ERR_MAX);
        push_tick(ERR_MAX, TILT_MAX, 0, 0);
        push_tick(0, -TILT_MAX, 0, 0);
        push_tick(ERR_MIN, ERR_MAX, ERR_MIN, ERR_MIN);
        push_tick(0, ERR_MIN, ERR_MAX, ERR_MAX);
        push_tick(1000, -(TILT_MAX - 1), ERR_MIN, ERR_MAX);
        push_tick(-1000, TILT_MAX - 1, ERR_MAX, ERR_MIN);
        push_tick(ERR_MAX, 0, ERR_MIN, 0);
        push_tick(ERR_MAX, 100, ERR_MAX, 0);
        push_tick(ERR_MIN, -100, 0, ERR_MIN);
        push_tick(ERR_MIN, 0, 0, ERR_MAX);
        push_tick(256, 2560, -2560, 1280);
        push_tick(-256, -2560, 2560, -1280);
        push_tick(0, 1, -1, 0);
        push_tick(0, -1, 1, 0);
        push_tick(ERR_MAX, 0, 0, 0);
        push_tick(0, 0, 0, 0);
        push_tick(0, 0, 0, 0);
        queue_random_ticks(120);
        wait_all_results();

        load_gains(random_gains(4));
        queue_random_ticks(120);
        wait_all_results();

        load_gains(random_gains(0));
        queue_random_ticks(110);
        wait_all_results();

        load_gains({8{24'h7FFFFF}});
        queue_random_ticks(100);
        wait_all_results();

        // The sender pauses halfway until every result is back.
        load_gains({8{24'h800000}});
        queue_random_ticks(50);
        wait_all_results();
        queue_random_ticks(50);
        wait_all_results();

        load_gains('0);
        queue_random_ticks(60);
        wait_all_results();

        load_gains(random_gains(6));
        queue_random_ticks(150);
        wait_all_results();

        calm = 1'b1;
        load_gains(cbp_pkg::GAIN_RESET);
        queue_random_ticks(130);
        wait_all_results();

        repeat (12) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("cascaded_balance_pid regression: pass");
        end
        else
        begin
            $display("cascaded_balance_pid regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/cbp_pkg.sv
design/cbp_gain_regs.sv
design/cbp_pid_term.sv
design/cbp_core.sv
design/cascaded_balance_pid.sv
dv/cascaded_balance_pid_tb.sv
